// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define LHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/lha_pkg.sv -----
package lha_pkg;

  // Heap geometry, fixed by the field widths
  localparam int HeapUnits = 4096;
  localparam int UnitBytes = 16;
  localparam int UnitShift = $clog2(UnitBytes);
  localparam int UnitW     = 12;
  localparam int SizeW     = 13;
  localparam int BytesW    = 16;
  localparam int LimitW    = 13;
  localparam int StepW     = 4;
  localparam int NumSteps  = 13;

  localparam logic [LimitW-1:0] LimitReset = 13'd4096;

  // Register map: bit 2 of the byte address selects the register
  typedef enum logic [0:0] {
    RegHeapLimit = 1'b0
  } lha_reg_e;

  // Input beat
  typedef struct packed {
    logic              mode;
    logic [BytesW-1:0] request_bytes;
    logic [UnitW-1:0]  block_unit;
  } lha_req_t;

  // Result beat
  typedef struct packed {
    logic [UnitW-1:0] granted_unit;
    logic             failed;
  } lha_rsp_t;

  // Block header word
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] back;
    logic             in_use;
  } lha_hdr_t;

  // Header read address select
  typedef enum logic [1:0] {
    RaTopM1,
    RaUnitM1,
    RaTM1,
    RaPrevM1
  } lha_ra_e;

  // Datapath operation
  typedef enum logic [2:0] {
    OpNone,
    OpAllocSum,
    OpAllocCommit,
    OpFreeLatch,
    OpMerge,
    OpMergeWrite,
    OpWalkStep,
    OpWalkEnd
  } lha_op_e;

  // Jump condition
  typedef enum logic [2:0] {
    JcNext,
    JcAlways,
    JcDispatch,
    JcFreeBad,
    JcIsTop,
    JcBackGe,
    JcTZero,
    JcFreed
  } lha_jc_e;

  // Microcode steps; fall-through order matters
  typedef enum logic [StepW-1:0] {
    StIdle,
    StA0,
    StA1,
    StA2,
    StF0,
    StF1,
    StM0,
    StM1,
    StM2,
    StW0,
    StW1,
    StW2,
    StEmit0
  } lha_step_e;

  typedef struct packed {
    lha_ra_e   ra;
    lha_op_e   op;
    lha_jc_e   jc;
    lha_step_e target;
    logic      emit;
  } lha_cw_t;

  // Control store, one word per step
  localparam lha_cw_t UCode [NumSteps] = '{
    '{RaTopM1,  OpNone,        JcDispatch, StF0,    1'b0},  // StIdle
    '{RaTopM1,  OpNone,        JcNext,     StIdle,  1'b0},  // StA0: read top header
    '{RaTopM1,  OpAllocSum,    JcNext,     StIdle,  1'b0},  // StA1: new top
    '{RaTopM1,  OpAllocCommit, JcAlways,   StIdle,  1'b1},  // StA2: check, write
    '{RaUnitM1, OpNone,        JcFreeBad,  StEmit0, 1'b0},  // StF0: read header
    '{RaUnitM1, OpFreeLatch,   JcIsTop,    StW0,    1'b0},  // StF1: latch header
    '{RaPrevM1, OpNone,        JcBackGe,   StM2,    1'b0},  // StM0: read previous
    '{RaPrevM1, OpMerge,       JcNext,     StIdle,  1'b0},  // StM1: merge back
    '{RaUnitM1, OpMergeWrite,  JcAlways,   StIdle,  1'b1},  // StM2: mark free
    '{RaTM1,    OpNone,        JcTZero,    StW2,    1'b0},  // StW0: read walk header
    '{RaTM1,    OpWalkStep,    JcFreed,    StW0,    1'b0},  // StW1: step back
    '{RaTM1,    OpWalkEnd,     JcAlways,   StIdle,  1'b1},  // StW2: set top
    '{RaTM1,    OpNone,        JcAlways,   StIdle,  1'b1}   // StEmit0: ignored free
  };

  // Move a data unit back by d, saturating at heap start; a zero d also lands there
  function automatic logic [UnitW-1:0] lha_step_back(logic [UnitW-1:0] u,
                                                     logic [SizeW-1:0] d);
    logic [UnitW-1:0] r;
    if (d == '0 || d >= {1'b0, u}) begin
      r = '0;
    end else begin
      r = u - d[UnitW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/lha_stream_if.sv -----
// Valid/ready channel carrying one payload beat
interface lha_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/lifo_heap_allocator_core.sv -----
// Stack-like heap allocator over 4096 units of 16 bytes. Each request beat
// either allocates (mode 0, size in bytes rounded up to units) or frees the
// block at block_unit (mode 1); each gives one result beat carrying the
// granted data unit, or a failed flag when the block would pass the
// heap_limit_units register (APB, byte address 0). One request is in work at
// a time; a new request is taken while the previous result still waits on
// the output. Block headers live in a 4096 x 27 single-port-read RAM that a
// microcoded sequencer drives, one header access per step. A free of a non-top
// block skips the merge with its predecessor when its back distance reaches
// the heap start; a free of the top block walks back over the freed blocks
// below it; an ignored free goes straight to its result. A result still
// waiting on the output holds the sequencer at its emit step. Headers hold
// no reset value.
`include "assert_macros.svh"

module lifo_heap_allocator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lha_stream_if.sink           req_i,
  lha_stream_if.source         rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int UW = lha_pkg::UnitW;
  localparam int SW = lha_pkg::SizeW;
  localparam int LW = lha_pkg::LimitW;

  // Sequencer
  lha_pkg::lha_step_e upc_q, upc_d;
  lha_pkg::lha_cw_t   cw;
  logic               accept;
  logic               stall;
  logic               hold;
  logic               jump;
  logic               advance;

  // Datapath registers
  logic [UW-1:0]   top_q;
  logic [LW-1:0]   limit_q;
  logic [SW-1:0]   size_q;
  logic [UW-1:0]   unit_q;
  logic [UW+1:0]   nt_q;
  logic [SW-1:0]   back_q;
  logic [SW-1:0]   hsize_q;
  logic [UW-1:0]   t_q;
  logic            rsp_valid_q;
  lha_pkg::lha_rsp_t rsp_q;

  // Datapath logic
  lha_pkg::lha_hdr_t hdr_rd;
  lha_pkg::lha_hdr_t hdr_wr;
  logic [lha_pkg::BytesW:0] bytes_up;
  logic [SW-1:0]   req_size;
  logic [UW+1:0]   alloc_back;
  logic [UW+1:0]   alloc_nt;
  logic [LW-1:0]   lim_eff;
  logic            alloc_fail;
  logic [SW:0]     merge_total;
  logic            merge_ok;
  logic [UW-1:0]   ram_raddr;
  logic [UW-1:0]   ram_waddr;
  logic            ram_we;
  logic [$bits(lha_pkg::lha_hdr_t)-1:0] ram_rdata;
  logic            cfg_we;

  // Control word fetch and handshake
  assign cw          = lha_pkg::UCode[upc_q];
  assign req_i.ready = (upc_q == lha_pkg::StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign stall       = cw.emit && rsp_valid_q && !rsp_o.ready;
  assign hold        = stall || (cw.jc == lha_pkg::JcDispatch && !accept);
  assign advance     = !hold;

  // Jump condition
  always_comb begin
    case (cw.jc)
      lha_pkg::JcNext:     jump = 1'b0;
      lha_pkg::JcAlways:   jump = 1'b1;
      lha_pkg::JcDispatch: jump = req_i.data.mode;
      lha_pkg::JcFreeBad:  jump = (unit_q == '0) || (unit_q > top_q);
      lha_pkg::JcIsTop:    jump = (unit_q == top_q);
      lha_pkg::JcBackGe:   jump = (back_q >= {1'b0, unit_q});
      lha_pkg::JcTZero:    jump = (t_q == '0);
      lha_pkg::JcFreed:    jump = !hdr_rd.in_use;
      default:             jump = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    upc_d = upc_q;
    if (!hold) begin
      if (jump) begin
        upc_d = cw.target;
      end else begin
        upc_d = lha_pkg::lha_step_e'(upc_q + lha_pkg::StepW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= lha_pkg::StIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Request size in units
  assign bytes_up = {1'b0, req_i.data.request_bytes} +
                    (lha_pkg::BytesW + 1)'(lha_pkg::UnitBytes - 1);
  assign req_size = SW'(bytes_up >> lha_pkg::UnitShift);

  // Header RAM read address
  always_comb begin
    case (cw.ra)
      lha_pkg::RaTopM1:  ram_raddr = top_q - UW'(1);
      lha_pkg::RaUnitM1: ram_raddr = unit_q - UW'(1);
      lha_pkg::RaTM1:    ram_raddr = t_q - UW'(1);
      lha_pkg::RaPrevM1: ram_raddr = unit_q - back_q[UW-1:0] - UW'(1);
      default:           ram_raddr = top_q - UW'(1);
    endcase
  end

  assign hdr_rd = lha_pkg::lha_hdr_t'(ram_rdata);

  // Allocate arithmetic
  assign alloc_back = (UW+2)'(1) +
                      ((top_q != '0) ? {1'b0, hdr_rd.size} : (UW+2)'(0));
  assign alloc_nt   = {2'b00, top_q} + alloc_back;
  assign lim_eff    = (limit_q > LW'(lha_pkg::HeapUnits)) ?
                      LW'(lha_pkg::HeapUnits) : limit_q;
  assign alloc_fail = (nt_q >= (UW+2)'(lha_pkg::HeapUnits)) ||
                      (({1'b0, nt_q} + {2'b00, size_q}) > {2'b00, lim_eff});

  // Merge with a freed predecessor
  assign merge_total = {1'b0, back_q} + {1'b0, hdr_rd.back};
  assign merge_ok    = !hdr_rd.in_use && (merge_total <= {2'b00, unit_q});

  // Header write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = unit_q - UW'(1);
    hdr_wr    = '{size: hsize_q, back: back_q, in_use: 1'b0};
    if (advance && cw.op == lha_pkg::OpAllocCommit) begin
      ram_we    = !alloc_fail;
      ram_waddr = nt_q[UW-1:0] - UW'(1);
      hdr_wr    = '{size: size_q, back: back_q, in_use: 1'b1};
    end else if (advance && cw.op == lha_pkg::OpMergeWrite) begin
      ram_we = 1'b1;
    end
  end

  lha_ram #(
    .WIDTH ($bits(lha_pkg::lha_hdr_t)),
    .DEPTH (lha_pkg::HeapUnits)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (hdr_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q <= req_size;
      unit_q <= req_i.data.block_unit;
    end
    if (advance) begin
      case (cw.op)
        lha_pkg::OpAllocSum: begin
          nt_q   <= alloc_nt;
          back_q <= alloc_back[SW-1:0];
        end
        lha_pkg::OpFreeLatch: begin
          hsize_q <= hdr_rd.size;
          back_q  <= hdr_rd.back;
          t_q     <= lha_pkg::lha_step_back(top_q, hdr_rd.back);
        end
        lha_pkg::OpMerge: begin
          if (merge_ok) begin
            back_q <= merge_total[SW-1:0];
          end
        end
        lha_pkg::OpWalkStep: begin
          if (!hdr_rd.in_use) begin
            t_q <= lha_pkg::lha_step_back(t_q, hdr_rd.back);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Top pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else if (advance) begin
      if (cw.op == lha_pkg::OpAllocCommit && !alloc_fail) begin
        top_q <= nt_q[UW-1:0];
      end else if (cw.op == lha_pkg::OpWalkEnd) begin
        top_q <= t_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance && cw.emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cw.emit) begin
      rsp_q.failed       <= (cw.op == lha_pkg::OpAllocCommit) && alloc_fail;
      rsp_q.granted_unit <= (cw.op == lha_pkg::OpAllocCommit && !alloc_fail) ?
                            nt_q[UW-1:0] : '0;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Configuration port
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == lha_pkg::RegHeapLimit);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lha_pkg::RegHeapLimit) ? 32'(limit_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lha_pkg::LimitReset;
    end else if (cfg_we) begin
      limit_q <= pwdata[LW-1:0];
    end
  end

  // Assertions
  `LHA_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_ni |-> !rsp_o.valid, "result during reset")
  `LHA_ASSERT(a_top_only_at_emit, !(cw.emit && advance) |=> $stable(top_q), "top moved mid-op")
  `LHA_ASSERT(a_alloc_grows_top, cw.op == lha_pkg::OpAllocCommit && advance && !alloc_fail |=> top_q > $past(top_q), "alloc did not grow top")
  `LHA_ASSERT(a_walk_below_top, upc_q == lha_pkg::StW0 |-> t_q < top_q, "walk pointer not below top")
  `LHA_ASSERT(a_fail_zero_unit, rsp_o.valid && rsp_o.data.failed |-> rsp_o.data.granted_unit == '0, "failed result with unit")

endmodule

// ----- hw/rtl/lha_ram.sv -----
// Single write port, single registered read port
module lha_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- tb/sv/lifo_heap_allocator_checker.sv -----
package lha_tb_pkg;

  // Request kinds carried in the mode field
  typedef enum logic {
    ModeAlloc = 1'b0,
    ModeFree  = 1'b1
  } heap_mode_e;

endpackage

module lifo_heap_allocator_checker
  import lha_pkg::*, lha_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  lha_req_t           req_data_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_ready_i,
  input  lha_rsp_t           rsp_data_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               done_i,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow heap: top pointer, limit register and one header per unit
  logic [UnitW-1:0]  top_unit;
  logic [LimitW-1:0] heap_limit;
  logic [SizeW-1:0]  hdr_size [HeapUnits];
  logic [SizeW-1:0]  hdr_back [HeapUnits];
  logic              hdr_used [HeapUnits];

  lha_rsp_t    expected_grants [$];
  int unsigned errors = 0;

  assign fail_count_o = errors;

  // Step a data unit back by d; lands on heap start when d is 0 or too far
  function automatic int back_off(int u, int d);
    return (d == 0 || d >= u) ? 0 : u - d;
  endfunction

  function automatic bit freed_at(int u);
    return u > 0 && u <= HeapUnits && !hdr_used[u-1];
  endfunction

  // Apply one request to the shadow heap and return the result beat it gives
  function automatic lha_rsp_t predict_heap_op(lha_req_t op);
    lha_rsp_t res;
    int lim, back, new_top, size, walk, prev, total, u;
    res = '0;
    if (op.mode == ModeAlloc) begin
      lim = (int'(heap_limit) > HeapUnits) ? HeapUnits : int'(heap_limit);
      back = 1;
      if (top_unit != '0) back += int'(hdr_size[top_unit-1]);
      new_top = int'(top_unit) + back;
      size = (int'(op.request_bytes) + UnitBytes - 1) / UnitBytes;
      if (new_top >= HeapUnits || new_top + size > lim) begin
        res.failed = 1'b1;
      end else begin
        hdr_back[new_top-1] = SizeW'(back);
        hdr_size[new_top-1] = SizeW'(size);
        hdr_used[new_top-1] = 1'b1;
        top_unit = UnitW'(new_top);
        res.granted_unit = UnitW'(new_top);
      end
    end else begin
      u = int'(op.block_unit);
      // unit zero, or past the top: nothing happens
      if (u != 0 && u <= int'(top_unit)) begin
        if (u == int'(top_unit)) begin
          // pop the top, then keep popping over freed blocks
          walk = back_off(u, int'(hdr_back[u-1]));
          while (freed_at(walk)) walk = back_off(walk, int'(hdr_back[walk-1]));
          top_unit = UnitW'(walk);
        end else begin
          // mark free, absorbing a freed neighbor below if it fits
          back = int'(hdr_back[u-1]);
          if (back < u) begin
            prev = u - back;
            if (freed_at(prev)) begin
              total = back + int'(hdr_back[prev-1]);
              if (total <= u) back = total;
            end
          end
          hdr_back[u-1] = SizeW'(back);
          hdr_used[u-1] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // Track config writes, check result beats, predict request beats
  always @(posedge clk_i or negedge rst_ni) begin
    lha_rsp_t want;
    if (!rst_ni) begin
      top_unit = '0;
      heap_limit = LimitReset;
      expected_grants.delete();
      for (int i = 0; i < HeapUnits; i++) begin
        hdr_size[i] = '0;
        hdr_back[i] = '0;
        hdr_used[i] = 1'b0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegHeapLimit) begin
        heap_limit = pwdata[LimitW-1:0];
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_grants.size() == 0) begin
          $error("result beat with nothing pending: granted_unit %0d failed %0b",
                 rsp_data_i.granted_unit, rsp_data_i.failed);
          errors++;
        end else begin
          want = expected_grants.pop_front();
          if (rsp_data_i.granted_unit !== want.granted_unit) begin
            $error("granted_unit: expected %0d, actual %0d",
                   want.granted_unit, rsp_data_i.granted_unit);
            errors++;
          end
          if (rsp_data_i.failed !== want.failed) begin
            $error("failed: expected %0b, actual %0b", want.failed, rsp_data_i.failed);
            errors++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_grants.push_back(predict_heap_op(req_data_i));
      end
    end
  end

  // Anything still pending at the end never came out
  always @(posedge done_i) begin
    if (expected_grants.size() != 0) begin
      $error("%0d result beats never arrived", expected_grants.size());
      errors++;
    end
  end

endmodule

// ----- tb/sv/lifo_heap_allocator_core_test.sv -----
module lifo_heap_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lha_pkg::*;
  import lha_tb_pkg::*;

  localparam int PhaseBeats     = 255;
  localparam int NumPhases      = 6;
  localparam int HoldCycles     = 120;
  localparam int WatchdogCycles = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        done;

  // steady: no idling on either side; hold_rsp: long receiver stall
  bit steady   = 1'b0;
  bit hold_rsp = 1'b0;

  // Bookkeeping for pacing and for picking units to free
  int unsigned sent = 0, returned = 0, quiet_cycles = 0;
  int unsigned alloc_beats = 0, free_beats = 0, refused = 0, limit_writes = 0;
  int          max_grant = 0;
  bit          ever_seen [HeapUnits];
  int          live_q [$];
  int          ever_q [$];
  int unsigned fail_count;

  lha_stream_if #(.payload_t(lha_req_t)) req_if ();
  lha_stream_if #(.payload_t(lha_rsp_t)) rsp_if ();

  lifo_heap_allocator_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lifo_heap_allocator_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_data_i   (req_if.data),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_data_i   (rsp_if.data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .done_i       (done),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count beats, learn granted units, and stop a hung run
  always @(posedge clk_i) begin
    lha_rsp_t got;
    bit       moved;
    got = rsp_if.data;
    moved = 1'b0;
    if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      sent++;
      moved = 1'b1;
      if (req_if.data.mode == ModeAlloc) alloc_beats++;
      else free_beats++;
    end
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      returned++;
      moved = 1'b1;
      if (got.failed) begin
        refused++;
      end else if (got.granted_unit != '0) begin
        live_q.push_back(int'(got.granted_unit));
        if (!ever_seen[got.granted_unit]) begin
          ever_seen[got.granted_unit] = 1'b1;
          ever_q.push_back(int'(got.granted_unit));
        end
        if (int'(got.granted_unit) > max_grant) max_grant = int'(got.granted_unit);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WatchdogCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random back-pressure, or one long stall on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  function automatic lha_req_t alloc_beat(logic [BytesW-1:0] bytes);
    lha_req_t b;
    b.mode = ModeAlloc;
    b.request_bytes = bytes;
    b.block_unit = UnitW'($urandom_range(0, HeapUnits - 1));
    return b;
  endfunction

  function automatic lha_req_t free_beat(logic [UnitW-1:0] unit);
    lha_req_t b;
    b.mode = ModeFree;
    b.request_bytes = BytesW'($urandom_range(0, 65535));
    b.block_unit = unit;
    return b;
  endfunction

  // Offer one beat, with a random gap first; called and returns at negedge
  task automatic send_beat(input lha_req_t beat);
    while (!steady && $urandom_range(0, 99) < 14) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= beat;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (returned != sent);
  endtask

  // All results in, then let the block settle
  task automatic drain();
    wait_results();
    repeat (8) @(negedge clk_i);
  endtask

  // APB write of the limit register: setup then access
  task automatic write_limit(input logic [LimitW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegHeapLimit, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_writes++;
  endtask

  // Mostly allocations and frees of recent blocks; a few stale and ignored frees
  task automatic random_beat(output lha_req_t beat);
    int roll, span, pick;
    roll = $urandom_range(0, 99);
    if (roll >= 55 && roll < 88 && live_q.size() > 0) begin
      span = (live_q.size() < 6) ? live_q.size() : 6;
      pick = live_q.size() - 1 - $urandom_range(0, span - 1);
      beat = free_beat(UnitW'(live_q[pick]));
      live_q.delete(pick);
    end else if (roll >= 88 && roll < 95 && ever_q.size() > 0) begin
      beat = free_beat(UnitW'(ever_q[$urandom_range(0, ever_q.size() - 1)]));
    end else if (roll >= 95) begin
      // top is only exact with nothing in flight; then pick zero or past it
      wait_results();
      if (max_grant >= HeapUnits - 1 || $urandom_range(0, 1) == 0) begin
        beat = free_beat('0);
      end else begin
        beat = free_beat(UnitW'($urandom_range(max_grant + 1, HeapUnits - 1)));
      end
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) beat = alloc_beat(BytesW'($urandom_range(0, 96)));
      else if (roll < 92) beat = alloc_beat(BytesW'($urandom_range(97, 1024)));
      else beat = alloc_beat(BytesW'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    lha_req_t          beat;
    logic [LimitW-1:0] limits [NumPhases];

    req_if.valid = 1'b0;
    req_if.data  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    done    = 1'b0;
    rst_ni  = 1'b1;
    // reset edge after time zero so every reset process sees it
    #1 rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty heap, whole-heap blocks, heap end, merges and back walks
    send_beat(free_beat(12'd5));
    send_beat(free_beat(12'd0));
    send_beat(alloc_beat(16'd65535));
    send_beat(alloc_beat(16'd65520));
    send_beat(alloc_beat(16'd0));
    send_beat(free_beat(12'd1));
    send_beat(alloc_beat(16'd65504));
    send_beat(alloc_beat(16'd0));
    send_beat(free_beat(12'd1));
    send_beat(alloc_beat(16'd0));
    send_beat(alloc_beat(16'd1));
    send_beat(alloc_beat(16'd16));
    send_beat(alloc_beat(16'd17));
    send_beat(alloc_beat(16'd32));
    send_beat(free_beat(12'd4));
    send_beat(free_beat(12'd6));
    send_beat(free_beat(12'd2));
    send_beat(free_beat(12'd9));
    send_beat(free_beat(12'd1));
    send_beat(free_beat(12'd4095));
    drain();

    // Zero limit refuses everything; a limit of one fits one empty block
    write_limit(13'd0);
    send_beat(alloc_beat(16'd0));
    drain();
    write_limit(13'd1);
    send_beat(alloc_beat(16'd0));
    send_beat(alloc_beat(16'd0));
    send_beat(free_beat(12'd1));
    drain();

    limits[0] = 13'd8191;
    limits[1] = LimitReset;
    limits[2] = 13'd300;
    limits[3] = LimitW'($urandom_range(1, HeapUnits));
    limits[4] = 13'd40;
    limits[5] = LimitReset;

    // Random phases, heap state carried across limit changes
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(limits[p]);
      steady = (p == 1);
      if (p == 2) hold_rsp = 1'b1;
      repeat (PhaseBeats) begin
        random_beat(beat);
        send_beat(beat);
      end
      drain();
    end
    steady = 1'b0;

    done = 1'b1;
    @(negedge clk_i);
    $display("Ran %0d beats: %0d allocations (%0d refused), %0d frees, %0d limit writes",
             sent, alloc_beats, refused, free_beats, limit_writes);
    $display("Distinct data units granted: %0d, highest %0d", ever_q.size(), max_grant);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lha_pkg.sv
hw/rtl/lha_stream_if.sv
hw/rtl/lha_ram.sv
hw/rtl/lifo_heap_allocator_core.sv
tb/sv/lifo_heap_allocator_checker.sv
tb/sv/lifo_heap_allocator_core_test.sv
